@@ design/phtm_pkg.sv @@
// shared types, constants and codes of the per-host traffic meter
package phtm_pkg;

  localparam int unsigned EntriesDef = 512;
  localparam int unsigned BucketsDef = 40;

  localparam int unsigned CntW  = 40;
  localparam int unsigned PeakW = 44;
  localparam int unsigned AvgW  = 50;
  localparam int unsigned WinW  = 6;
  localparam int unsigned SlotW = 9;
  localparam int unsigned StatW = 3;
  localparam int unsigned TimeW = 32;

  // result status codes
  localparam logic [StatW-1:0] StUpdated = 3'd0;
  localparam logic [StatW-1:0] StCreated = 3'd1;
  localparam logic [StatW-1:0] StFull    = 3'd2;
  localparam logic [StatW-1:0] StReadOk  = 3'd3;
  localparam logic [StatW-1:0] StNoEntry = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CfgShort = 2'd0;
  localparam logic [1:0] CfgMid   = 2'd1;
  localparam logic [1:0] CfgLong  = 2'd2;

  // item command codes
  localparam logic CmdAccount = 1'b0;
  localparam logic CmdRead    = 1'b1;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v6;
  } key_t;

  typedef struct packed {
    logic [63:0]      rx;
    logic [63:0]      tx;
    logic [PeakW-1:0] peak;
    logic [TimeW-1:0] last;
  } ent_t;

  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic [CntW-1:0]  rx;
    logic [CntW-1:0]  tx;
  } bkt_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mod_step;
    logic       scan;
    logic       pick;
    logic       drop;
    logic       base;
    logic       clr;
    logic       bupd;
    logic       peak;
    logic       eupd;
    logic       chk;
    logic       eget;
    logic       walk;
    logic       div_go;
    logic       div_take;
    logic [1:0] div_sel;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_read;
    logic mod_done;
    logic hit;
    logic miss;
    logic full;
    logic is_new;
    logic clr_last;
    logic idx_bad;
    logic walk_done;
    logic div_done;
  } dp_stat_t;

endpackage

@@ design/per_host_traffic_meter_unit.sv @@
// top level of the per-host traffic meter: controller plus datapath
//
//  channel   handshake              payload
//  item in   start / busy           cmd_i, addr_*, byte_count_i, is_rx_i, now_seconds_i,
//                                   entry_index_i
//  result    done_o (one cycle)     status_o, slot_o, host_*, totals, peak, averages,
//                                   last_seen_time_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// account item: the key search takes one entry per cycle, and a new host first has its
//   BUCKETS buckets cleared
// read item: a walk over the BUCKETS buckets, then the serial divider run once per window;
//   a missing entry is answered without either
// reset clears the entry count and controller and sets the windows to 2, 10, 40; no clearing pass
// results cannot be stalled; a new item is taken once busy falls
module per_host_traffic_meter_unit #(
  parameter int unsigned ENTRIES = phtm_pkg::EntriesDef,
  parameter int unsigned BUCKETS = phtm_pkg::BucketsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [phtm_pkg::WinW-1:0]  cfg_wdata_i,
  input  logic                       cmd_i,
  input  logic [63:0]                addr_hi_i,
  input  logic [63:0]                addr_lo_i,
  input  logic                       addr_is_v6_i,
  input  logic [15:0]                byte_count_i,
  input  logic                       is_rx_i,
  input  logic [31:0]                now_seconds_i,
  input  logic [8:0]                 entry_index_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [8:0]                 slot_o,
  output logic [63:0]                host_hi_o,
  output logic [63:0]                host_lo_o,
  output logic                       host_is_v6_o,
  output logic [63:0]                rx_bytes_total_o,
  output logic [63:0]                tx_bytes_total_o,
  output logic [43:0]                peak_rate_o,
  output logic [49:0]                avg_short_o,
  output logic [49:0]                avg_mid_o,
  output logic [49:0]                avg_long_o,
  output logic [31:0]                last_seen_time_o
);
  import phtm_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing
  phtm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // table, buckets and arithmetic
  phtm_dp #(
    .ENTRIES (ENTRIES),
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_in_i         (cmd_i),
    .addr_hi_i        (addr_hi_i),
    .addr_lo_i        (addr_lo_i),
    .addr_is_v6_i     (addr_is_v6_i),
    .byte_count_i     (byte_count_i),
    .is_rx_i          (is_rx_i),
    .now_seconds_i    (now_seconds_i),
    .entry_index_i    (entry_index_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .host_hi_o        (host_hi_o),
    .host_lo_o        (host_lo_o),
    .host_is_v6_o     (host_is_v6_o),
    .rx_bytes_total_o (rx_bytes_total_o),
    .tx_bytes_total_o (tx_bytes_total_o),
    .peak_rate_o      (peak_rate_o),
    .avg_short_o      (avg_short_o),
    .avg_mid_o        (avg_mid_o),
    .avg_long_o       (avg_long_o),
    .last_seen_time_o (last_seen_time_o)
  );

endmodule

@@ design/phtm_div.sv @@
// bit-serial restoring divider by a window length
module phtm_div #(
  parameter int unsigned DW = 50
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [phtm_pkg::WinW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DW-1:0]              quot_o
);
  import phtm_pkg::*;

  localparam int unsigned NW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [WinW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [WinW:0] trial;

  // one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = NW'(DW);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = WinW'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[WinW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ design/phtm_dp.sv @@
// datapath: host table, bucket memory, modulo, bucket walk and result registers
module phtm_dp #(
  parameter int unsigned ENTRIES = phtm_pkg::EntriesDef,
  parameter int unsigned BUCKETS = phtm_pkg::BucketsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  phtm_pkg::ctl_cmd_t         cmd_i,
  output phtm_pkg::dp_stat_t         stat_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [phtm_pkg::WinW-1:0]  cfg_wdata_i,
  input  logic                       cmd_in_i,
  input  logic [63:0]                addr_hi_i,
  input  logic [63:0]                addr_lo_i,
  input  logic                       addr_is_v6_i,
  input  logic [15:0]                byte_count_i,
  input  logic                       is_rx_i,
  input  logic [31:0]                now_seconds_i,
  input  logic [8:0]                 entry_index_i,
  output logic [2:0]                 status_o,
  output logic [8:0]                 slot_o,
  output logic [63:0]                host_hi_o,
  output logic [63:0]                host_lo_o,
  output logic                       host_is_v6_o,
  output logic [63:0]                rx_bytes_total_o,
  output logic [63:0]                tx_bytes_total_o,
  output logic [43:0]                peak_rate_o,
  output logic [49:0]                avg_short_o,
  output logic [49:0]                avg_mid_o,
  output logic [49:0]                avg_long_o,
  output logic [31:0]                last_seen_time_o
);
  import phtm_pkg::*;

  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(ENTRIES + 1);
  localparam int unsigned SCW = $clog2(ENTRIES + 2);
  localparam int unsigned XW  = (CW > SlotW) ? CW : SlotW;
  localparam int unsigned BD  = ENTRIES * BUCKETS;
  localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int unsigned RW  = $clog2(BUCKETS);
  localparam int unsigned KW  = $clog2(BUCKETS + 1);
  localparam int unsigned SW  = CntW + 1 + $clog2(BUCKETS);
  localparam int unsigned DW  = SW + 3;
  // reciprocal of BUCKETS, exact for every 32-bit second
  localparam int unsigned LW  = $clog2(BUCKETS);
  localparam int unsigned MW  = 33;
  localparam logic [MW-1:0] ModMul =
    MW'(((64'd1 << (32 + LW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  // configuration registers
  logic [WinW-1:0] win_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= WinW'(2);
      win_q[1] <= WinW'(10);
      win_q[2] <= WinW'(40);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShort: win_q[0] <= cfg_wdata_i;
        CfgMid:   win_q[1] <= cfg_wdata_i;
        CfgLong:  win_q[2] <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // latched item
  logic            rd_q;
  key_t            key_q;
  logic [15:0]     bytes_q;
  logic            isrx_q;
  logic [31:0]     now_q;
  logic [8:0]      idx_q;

  // control registers
  logic [CW-1:0]   count_q;
  logic [SCW-1:0]  scan_q;
  logic            cvld_q;
  logic [AW-1:0]   cidx_q;
  logic [AW-1:0]   e_q;
  logic            new_q;
  logic [1:0]      mcnt_q;
  logic [RW-1:0]   rem_q;
  logic [32+MW-1:0] prod_q;
  logic [31:0]     mod_q;
  logic [KW-1:0]   walk_q;
  logic            bvld_q;
  logic [BAW-1:0]  base_q;

  // memories and read data
  key_t key_mem [ENTRIES];
  ent_t ent_mem [ENTRIES];
  bkt_t bkt_mem [BD];
  key_t key_rd_q;
  ent_t ent_rd_q;
  bkt_t bkt_rd_q;

  logic [AW-1:0]  key_ra;
  logic [BAW-1:0] bkt_ra, bkt_wa;
  logic           bkt_we;
  bkt_t           bkt_wd;
  logic           ent_we;
  ent_t           ent_wd;

  logic           hit, miss, full, idx_bad;

  // work registers
  logic [CntW-1:0]  nrx_q, ntx_q;
  logic [PeakW-1:0] cur_q;
  logic [SW-1:0]    sum_q [3];

  assign hit     = cvld_q && (key_rd_q == key_q);
  assign miss    = !cvld_q && (scan_q >= SCW'(count_q));
  assign full    = (count_q == CW'(ENTRIES));
  assign idx_bad = XW'(idx_q) >= XW'(count_q);
  assign mod_q   = 32'(prod_q >> (32 + LW));

  assign stat_o.is_read   = rd_q;
  assign stat_o.mod_done  = (mcnt_q == 2'd2);
  assign stat_o.hit       = hit;
  assign stat_o.miss      = miss;
  assign stat_o.full      = full;
  assign stat_o.is_new    = new_q;
  assign stat_o.clr_last  = (walk_q == KW'(BUCKETS - 1));
  assign stat_o.idx_bad   = idx_bad;
  assign stat_o.walk_done = !bvld_q && (walk_q == KW'(BUCKETS));

  // memory addresses
  assign key_ra = cmd_i.scan ? scan_q[AW-1:0] : e_q;
  assign bkt_ra = base_q + BAW'(rd_q ? walk_q : KW'(rem_q));
  assign bkt_wa = base_q + BAW'(cmd_i.clr ? walk_q : KW'(rem_q));

  // bucket clear and update for an account item
  logic [CntW-1:0] orx, otx;
  logic [CntW:0]   radd, tadd;
  always_comb begin
    orx  = (bkt_rd_q.stamp == now_q) ? bkt_rd_q.rx : '0;
    otx  = (bkt_rd_q.stamp == now_q) ? bkt_rd_q.tx : '0;
    radd = {1'b0, orx} + (CntW+1)'(bytes_q);
    tadd = {1'b0, otx} + (CntW+1)'(bytes_q);
    bkt_we = cmd_i.clr || cmd_i.bupd;
    bkt_wd = '0;
    if (cmd_i.bupd) begin
      bkt_wd.stamp = now_q;
      bkt_wd.rx    = orx;
      bkt_wd.tx    = otx;
      if (isrx_q) begin
        bkt_wd.rx = radd[CntW] ? {CntW{1'b1}} : radd[CntW-1:0];
      end else begin
        bkt_wd.tx = tadd[CntW] ? {CntW{1'b1}} : tadd[CntW-1:0];
      end
    end
  end

  // entry record update
  ent_t old_ent;
  always_comb begin
    old_ent = new_q ? '0 : ent_rd_q;
    ent_we  = cmd_i.eupd;
    ent_wd  = old_ent;
    if (isrx_q) begin
      ent_wd.rx = old_ent.rx + 64'(bytes_q);
    end else begin
      ent_wd.tx = old_ent.tx + 64'(bytes_q);
    end
    ent_wd.peak = (cur_q > old_ent.peak) ? cur_q : old_ent.peak;
    ent_wd.last = now_q;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick && !hit) begin
      key_mem[count_q[AW-1:0]] <= key_q;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[e_q] <= ent_wd;
    end
    ent_rd_q <= ent_mem[e_q];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_wa] <= bkt_wd;
    end
    bkt_rd_q <= bkt_mem[bkt_ra];
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      cvld_q  <= 1'b0;
      new_q   <= 1'b0;
      mcnt_q  <= '0;
      rem_q   <= '0;
      walk_q  <= '0;
      bvld_q  <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_q   <= (cmd_in_i == CmdRead);
        scan_q <= '0;
        cvld_q <= 1'b0;
        mcnt_q <= '0;
      end
      if (cmd_i.mod_step && (mcnt_q != 2'd2)) begin
        mcnt_q <= mcnt_q + 2'd1;
      end
      // remainder from the quotient taken in the cycle before
      if (cmd_i.mod_step && (mcnt_q == 2'd1)) begin
        rem_q <= RW'(now_q - 32'(mod_q * BUCKETS));
      end
      if (cmd_i.scan) begin
        cvld_q <= (scan_q < SCW'(count_q));
        if (scan_q <= SCW'(count_q)) begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (cmd_i.pick) begin
        new_q <= !hit;
        if (!hit) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.chk) begin
        new_q <= 1'b0;
      end
      if (cmd_i.base) begin
        walk_q <= '0;
        bvld_q <= 1'b0;
      end
      if (cmd_i.clr) begin
        walk_q <= walk_q + 1'b1;
      end
      if (cmd_i.walk) begin
        bvld_q <= (walk_q < KW'(BUCKETS));
        if (walk_q < KW'(BUCKETS)) begin
          walk_q <= walk_q + 1'b1;
        end
      end
    end
  end

  // divider shared by the three windows
  logic [DW-1:0] div_quot;
  logic          div_done;
  phtm_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i ({sum_q[cmd_i.div_sel], 3'b000}),
    .divisor_i  (win_q[cmd_i.div_sel]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );
  assign stat_o.div_done = div_done;

  // age of a walked bucket against each window
  logic signed [32:0] age;
  logic [CntW:0]      bsum;
  assign age  = $signed({1'b0, now_q}) - $signed({1'b0, bkt_rd_q.stamp});
  assign bsum = {1'b0, bkt_rd_q.rx} + {1'b0, bkt_rd_q.tx};

  // payload registers
  logic [StatW-1:0] status_q;
  logic [SlotW-1:0] slot_q;
  key_t             host_q;
  logic [63:0]      rxt_q, txt_q;
  logic [PeakW-1:0] peak_q;
  logic [AvgW-1:0]  avg_q [3];
  logic [TimeW-1:0] last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= '{hi: addr_hi_i, lo: addr_lo_i, v6: addr_is_v6_i};
      bytes_q  <= byte_count_i;
      isrx_q   <= is_rx_i;
      now_q    <= now_seconds_i;
      idx_q    <= entry_index_i;
      status_q <= '0;
      slot_q   <= '0;
      host_q   <= '0;
      rxt_q    <= '0;
      txt_q    <= '0;
      peak_q   <= '0;
      last_q   <= '0;
      for (int w = 0; w < 3; w++) begin
        avg_q[w] <= '0;
      end
    end
    // now div BUCKETS by reciprocal multiply
    if (cmd_i.mod_step && (mcnt_q == 2'd0)) begin
      prod_q <= (32+MW)'(now_q) * (32+MW)'(ModMul);
    end
    if (cmd_i.pick) begin
      if (hit) begin
        e_q      <= cidx_q;
        status_q <= StUpdated;
        slot_q   <= SlotW'(cidx_q);
      end else begin
        e_q      <= count_q[AW-1:0];
        status_q <= StCreated;
        slot_q   <= SlotW'(count_q[AW-1:0]);
      end
    end
    if (cmd_i.scan) begin
      cidx_q <= scan_q[AW-1:0];
    end
    if (cmd_i.drop) begin
      status_q <= StFull;
      slot_q   <= '0;
    end
    if (cmd_i.chk) begin
      slot_q   <= idx_q;
      e_q      <= AW'(idx_q);
      status_q <= idx_bad ? StNoEntry : StReadOk;
    end
    if (cmd_i.base) begin
      base_q <= BAW'(e_q * BUCKETS);
      for (int w = 0; w < 3; w++) begin
        sum_q[w] <= '0;
      end
    end
    if (cmd_i.bupd) begin
      nrx_q <= bkt_wd.rx;
      ntx_q <= bkt_wd.tx;
    end
    if (cmd_i.peak) begin
      cur_q <= PeakW'({(CntW+1)'(nrx_q) + (CntW+1)'(ntx_q), 3'b000});
    end
    if (cmd_i.eget) begin
      host_q <= key_rd_q;
      rxt_q  <= ent_rd_q.rx;
      txt_q  <= ent_rd_q.tx;
      peak_q <= ent_rd_q.peak;
      last_q <= ent_rd_q.last;
    end
    // sum live buckets younger than each window
    if (cmd_i.walk && bvld_q && (bkt_rd_q.stamp != '0)) begin
      for (int w = 0; w < 3; w++) begin
        if (age < $signed({27'b0, win_q[w]})) begin
          sum_q[w] <= sum_q[w] + SW'(bsum);
        end
      end
    end
    if (cmd_i.div_take) begin
      avg_q[cmd_i.div_sel] <= (win_q[cmd_i.div_sel] == '0) ? '0 : AvgW'(div_quot);
    end
  end

  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign host_hi_o        = host_q.hi;
  assign host_lo_o        = host_q.lo;
  assign host_is_v6_o     = host_q.v6;
  assign rx_bytes_total_o = rxt_q;
  assign tx_bytes_total_o = txt_q;
  assign peak_rate_o      = peak_q;
  assign avg_short_o      = avg_q[0];
  assign avg_mid_o        = avg_q[1];
  assign avg_long_o       = avg_q[2];
  assign last_seen_time_o = last_q;

  // table fill never runs past its size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  // a host is added at most once per item and only by a miss
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1) && $past(cmd_i.pick))
    else $error("entry count moved unexpectedly");

  // bucket index stays in range
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < RW'(BUCKETS) || (BUCKETS == (1 << RW)))
    else $error("bucket index out of range");

  // a hit and a miss never show together
  a_hit_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> !(hit && miss))
    else $error("search reports hit and miss");

endmodule

@@ design/phtm_ctrl.sv @@
// controller state machine sequencing lookup, bucket update and read walk
module phtm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  phtm_pkg::dp_stat_t  stat_i,
  output phtm_pkg::ctl_cmd_t  cmd_o
);
  import phtm_pkg::*;

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SDisp = 5'd1;
  localparam logic [4:0] SMod  = 5'd2;
  localparam logic [4:0] SSrch = 5'd3;
  localparam logic [4:0] SBase = 5'd4;
  localparam logic [4:0] SClr  = 5'd5;
  localparam logic [4:0] SBrd  = 5'd6;
  localparam logic [4:0] SBupd = 5'd7;
  localparam logic [4:0] SPeak = 5'd8;
  localparam logic [4:0] SEupd = 5'd9;
  localparam logic [4:0] SChk  = 5'd10;
  localparam logic [4:0] SEget = 5'd11;
  localparam logic [4:0] SWalk = 5'd12;
  localparam logic [4:0] SDiv  = 5'd13;
  localparam logic [4:0] SDwt  = 5'd14;
  localparam logic [4:0] SResp = 5'd15;

  logic [4:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    cmd_o         = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SDisp;
        end
      end
      SDisp: state_d = stat_i.is_read ? SChk : SMod;
      SMod: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) begin
          state_d = SSrch;
        end
      end
      SSrch: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.pick = 1'b1;
          state_d    = SBase;
        end else if (stat_i.miss) begin
          if (stat_i.full) begin
            cmd_o.drop = 1'b1;
            state_d    = SResp;
          end else begin
            cmd_o.pick = 1'b1;
            state_d    = SBase;
          end
        end
      end
      SBase: begin
        cmd_o.base = 1'b1;
        if (stat_i.is_read) begin
          state_d = SEget;
        end else begin
          state_d = stat_i.is_new ? SClr : SBrd;
        end
      end
      SClr: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = SBrd;
        end
      end
      SBrd: state_d = SBupd;
      SBupd: begin
        cmd_o.bupd = 1'b1;
        state_d    = SPeak;
      end
      SPeak: begin
        cmd_o.peak = 1'b1;
        state_d    = SEupd;
      end
      SEupd: begin
        cmd_o.eupd = 1'b1;
        state_d    = SResp;
      end
      SChk: begin
        cmd_o.chk = 1'b1;
        state_d   = stat_i.idx_bad ? SResp : SBase;
      end
      SEget: begin
        cmd_o.eget = 1'b1;
        state_d    = SWalk;
      end
      SWalk: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          sel_d   = 2'd0;
          state_d = SDiv;
        end
      end
      SDiv: begin
        cmd_o.div_go = 1'b1;
        state_d      = SDwt;
      end
      SDwt: begin
        if (stat_i.div_done) begin
          cmd_o.div_take = 1'b1;
          if (sel_q == 2'd2) begin
            state_d = SResp;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = SDiv;
          end
        end
      end
      SResp: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign busy   = (state_q != SIdle);
  assign done_o = (state_q == SResp);

  // a result follows only finished work
  a_resp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == SEupd) || ($past(state_q) == SChk)
               || ($past(state_q) == SDwt) || ($past(state_q) == SSrch))
    else $error("result without finished work");

  // each item yields exactly one result before the next is taken
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe not single");

  // divider results are taken only for the three windows
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_take |-> (sel_q != 2'd3))
    else $error("window select out of range");

endmodule

@@ bench/testbench.sv @@
// self-checking testbench of the per-host traffic meter unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import phtm_pkg::*;

  localparam int unsigned NumHosts = 512;
  localparam int unsigned NumBkts  = 40;
  localparam int unsigned PoolSize = 24;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v6;
    logic [63:0] rx;
    logic [63:0] tx;
    logic [43:0] peak;
    logic [49:0] avg_s;
    logic [49:0] avg_m;
    logic [49:0] avg_l;
    logic [31:0] last;
  } meter_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [WinW-1:0] cfg_wdata_i = '0;
  logic cmd_i = 1'b0;
  logic [63:0] addr_hi_i = '0;
  logic [63:0] addr_lo_i = '0;
  logic addr_is_v6_i = 1'b0;
  logic [15:0] byte_count_i = '0;
  logic is_rx_i = 1'b0;
  logic [31:0] now_seconds_i = '0;
  logic [8:0] entry_index_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [8:0] slot_o;
  logic [63:0] host_hi_o, host_lo_o;
  logic host_is_v6_o;
  logic [63:0] rx_bytes_total_o, tx_bytes_total_o;
  logic [43:0] peak_rate_o;
  logic [49:0] avg_short_o, avg_mid_o, avg_long_o;
  logic [31:0] last_seen_time_o;

  // mirror of the meter table
  logic [5:0]  win_short, win_mid, win_long;
  int unsigned host_count;
  logic [63:0] tbl_hi [NumHosts];
  logic [63:0] tbl_lo [NumHosts];
  logic        tbl_v6 [NumHosts];
  logic [63:0] tbl_rx [NumHosts];
  logic [63:0] tbl_tx [NumHosts];
  logic [43:0] tbl_peak [NumHosts];
  logic [31:0] tbl_last [NumHosts];
  logic [31:0] bkt_stamp [NumHosts][NumBkts];
  logic [39:0] bkt_rx [NumHosts][NumBkts];
  logic [39:0] bkt_tx [NumHosts][NumBkts];

  meter_result_t expected_results[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned results_seen = 0;

  logic [63:0] pool_hi [PoolSize];
  logic [63:0] pool_lo [PoolSize];
  logic        pool_v6 [PoolSize];
  logic [31:0] clock_now;

  per_host_traffic_meter_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .cmd_i, .addr_hi_i, .addr_lo_i, .addr_is_v6_i, .byte_count_i, .is_rx_i,
    .now_seconds_i, .entry_index_i, .done_o, .status_o, .slot_o, .host_hi_o,
    .host_lo_o, .host_is_v6_o, .rx_bytes_total_o, .tx_bytes_total_o,
    .peak_rate_o, .avg_short_o, .avg_mid_o, .avg_long_o, .last_seen_time_o
  );

  always #6ns clk_i = ~clk_i;

  // bits per second over one window of live buckets
  function automatic logic [49:0] window_bits(int unsigned e, logic [5:0] win,
                                              logic [31:0] now);
    logic [63:0] sum;
    longint age;
    sum = '0;
    if (win == '0) return '0;
    for (int b = 0; b < NumBkts; b++) begin
      age = longint'({32'b0, now}) - longint'({32'b0, bkt_stamp[e][b]});
      if (bkt_stamp[e][b] != '0 && age < longint'(win))
        sum += {24'b0, bkt_rx[e][b]} + {24'b0, bkt_tx[e][b]};
    end
    return 50'((sum * 64'd8) / {58'b0, win});
  endfunction

  // update the mirror for one accepted item and queue its result
  task automatic predict_meter();
    meter_result_t r;
    int unsigned e, b;
    logic [40:0] s;
    logic [44:0] cur;
    r = '0;
    if (cmd_i == CmdRead) begin
      r.slot = entry_index_i;
      if (entry_index_i >= host_count) begin
        r.status = StNoEntry;
      end else begin
        e = entry_index_i;
        r.status = StReadOk;
        r.hi = tbl_hi[e];
        r.lo = tbl_lo[e];
        r.v6 = tbl_v6[e];
        r.rx = tbl_rx[e];
        r.tx = tbl_tx[e];
        r.peak = tbl_peak[e];
        r.avg_s = window_bits(e, win_short, now_seconds_i);
        r.avg_m = window_bits(e, win_mid, now_seconds_i);
        r.avg_l = window_bits(e, win_long, now_seconds_i);
        r.last = tbl_last[e];
      end
    end else begin
      for (e = 0; e < host_count; e++)
        if (tbl_hi[e] == addr_hi_i && tbl_lo[e] == addr_lo_i && tbl_v6[e] == addr_is_v6_i)
          break;
      if (e < host_count) begin
        r.status = StUpdated;
      end else if (host_count >= NumHosts) begin
        r.status = StFull;
      end else begin
        e = host_count;
        host_count++;
        tbl_hi[e] = addr_hi_i;
        tbl_lo[e] = addr_lo_i;
        tbl_v6[e] = addr_is_v6_i;
        tbl_rx[e] = '0;
        tbl_tx[e] = '0;
        tbl_peak[e] = '0;
        tbl_last[e] = '0;
        for (int k = 0; k < NumBkts; k++) begin
          bkt_stamp[e][k] = '0;
          bkt_rx[e][k] = '0;
          bkt_tx[e][k] = '0;
        end
        r.status = StCreated;
      end
      if (r.status != StFull) begin
        r.slot = 9'(e);
        b = now_seconds_i % NumBkts;
        // stale bucket is cleared on reuse
        if (bkt_stamp[e][b] != now_seconds_i) begin
          bkt_stamp[e][b] = now_seconds_i;
          bkt_rx[e][b] = '0;
          bkt_tx[e][b] = '0;
        end
        if (is_rx_i) begin
          tbl_rx[e] += 64'(byte_count_i);
          s = {1'b0, bkt_rx[e][b]} + 41'(byte_count_i);
          bkt_rx[e][b] = s[40] ? '1 : s[39:0];
        end else begin
          tbl_tx[e] += 64'(byte_count_i);
          s = {1'b0, bkt_tx[e][b]} + 41'(byte_count_i);
          bkt_tx[e][b] = s[40] ? '1 : s[39:0];
        end
        cur = ({5'b0, bkt_rx[e][b]} + {5'b0, bkt_tx[e][b]}) << 3;
        if (cur[44]) cur = {1'b0, {44{1'b1}}};
        if (cur[43:0] > tbl_peak[e]) tbl_peak[e] = cur[43:0];
        tbl_last[e] = now_seconds_i;
      end
    end
    expected_results.push_back(r);
  endtask

  // send one item after a random gap and wait until it is taken
  task automatic send_item(logic cmd, logic [63:0] hi, logic [63:0] lo, logic v6,
                           logic [15:0] bytes, logic rx, logic [31:0] now,
                           logic [8:0] idx);
    int unsigned gap;
    gap = $urandom_range(3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= cmd;
    addr_hi_i <= hi;
    addr_lo_i <= lo;
    addr_is_v6_i <= v6;
    byte_count_i <= bytes;
    is_rx_i <= rx;
    now_seconds_i <= now;
    entry_index_i <= idx;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_meter();
    items_sent++;
    if (cmd == CmdRead) reads_sent++;
  endtask

  task automatic account(logic [63:0] hi, logic [63:0] lo, logic v6, logic [15:0] bytes,
                         logic rx, logic [31:0] now);
    send_item(CmdAccount, hi, lo, v6, bytes, rx, now, 9'($urandom));
  endtask

  task automatic read_entry(logic [8:0] idx, logic [31:0] now);
    send_item(CmdRead, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
              16'($urandom), 1'($urandom), now, idx);
  endtask

  // wait until every result is in and the unit is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_window(logic [1:0] idx, logic [5:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgShort) win_short = val;
    else if (idx == CfgMid) win_mid = val;
    else if (idx == CfgLong) win_long = val;
  endtask

  task automatic set_windows(logic [5:0] ws, logic [5:0] wm, logic [5:0] wl);
    settle();
    write_window(CfgShort, ws);
    write_window(CfgMid, wm);
    write_window(CfgLong, wl);
  endtask

  // random traffic over the host pool around a moving clock
  task automatic random_traffic(int unsigned n);
    int unsigned p;
    logic [31:0] t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) clock_now = $urandom;
      else if ($urandom_range(3) == 0) clock_now += $urandom_range(3);
      t = clock_now + $urandom_range(2) - 1;
      if ($urandom_range(9) < 6) begin
        p = $urandom_range(PoolSize - 1);
        account(pool_hi[p], pool_lo[p], pool_v6[p], 16'($urandom), 1'($urandom), t);
      end else if ($urandom_range(9) == 0) begin
        read_entry(9'($urandom), t);
      end else begin
        read_entry(9'($urandom_range(host_count + 1)), t);
      end
    end
  endtask

  task automatic test_directed();
    // reads of an empty table
    read_entry(9'd0, 32'd0);
    read_entry(9'h1FF, 32'd0);
    // packet at second zero lands in a bucket that never counts
    account(64'd0, 64'hC0A8_0001, 1'b0, 16'd1500, 1'b1, 32'd0);
    read_entry(9'd0, 32'd0);
    account(64'd0, 64'hC0A8_0001, 1'b0, 16'hFFFF, 1'b0, 32'd1);
    account(64'd0, 64'hC0A8_0001, 1'b0, 16'd0, 1'b1, 32'd1);
    read_entry(9'd0, 32'd1);
    // same address bits, different family flag
    account(64'd0, 64'hC0A8_0001, 1'b1, 16'd64, 1'b1, 32'd2);
    account('1, '1, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    account('1, '1, 1'b1, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    read_entry(9'd2, 32'hFFFF_FFFF);
    // future bucket
    account(64'h2001_0DB8_0000_0000, 64'h1, 1'b1, 16'd1000, 1'b0, 32'd100);
    read_entry(9'd3, 32'd50);
    // stale bucket reused forty seconds later
    account(64'd0, 64'hC0A8_0001, 1'b0, 16'd700, 1'b1, 32'd41);
    read_entry(9'd0, 32'd41);
    account(64'd0, 64'hC0A8_0001, 1'b0, 16'd300, 1'b0, 32'd40);
    read_entry(9'd0, 32'd42);
    read_entry(9'd4, 32'd42);
    read_entry(9'd3, 32'd101);
  endtask

  task automatic test_windows();
    set_windows(6'd1, 6'd40, 6'd63);
    random_traffic(75);
    set_windows(6'd0, 6'd1, 6'd40);
    random_traffic(75);
    set_windows(6'd63, 6'd0, 6'd1);
    random_traffic(75);
    set_windows(6'($urandom), 6'($urandom), 6'($urandom));
    random_traffic(75);
  endtask

  task automatic test_random();
    set_windows(6'd2, 6'd10, 6'd40);
    random_traffic(250);
  endtask

  task automatic test_table_full();
    int unsigned n;
    settle();
    n = 0;
    while (host_count < NumHosts) begin
      account(64'hFEED_0000_0000_0000 | 64'(n), {$urandom, $urandom}, 1'($urandom),
              16'($urandom), 1'($urandom), clock_now + $urandom_range(2));
      n++;
    end
    // new hosts now bounce off the full table
    for (int i = 0; i < 4; i++)
      account(64'hBEEF_0000_0000_0000 | 64'(i), {$urandom, $urandom}, 1'b1,
              16'd99, 1'b1, clock_now);
    read_entry(9'h1FF, clock_now);
    read_entry(9'h1FE, clock_now);
    random_traffic(40);
  endtask

  // compare each strobed result with the oldest expectation
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    meter_result_t w;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 64'(status_o), 64'd0);
      end else begin
        w = expected_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", 64'(status_o), 64'(w.status));
        if (slot_o !== w.slot) report_mismatch("slot", 64'(slot_o), 64'(w.slot));
        if (host_hi_o !== w.hi) report_mismatch("host_hi", host_hi_o, w.hi);
        if (host_lo_o !== w.lo) report_mismatch("host_lo", host_lo_o, w.lo);
        if (host_is_v6_o !== w.v6) report_mismatch("host_is_v6", 64'(host_is_v6_o), 64'(w.v6));
        if (rx_bytes_total_o !== w.rx) report_mismatch("rx_bytes", rx_bytes_total_o, w.rx);
        if (tx_bytes_total_o !== w.tx) report_mismatch("tx_bytes", tx_bytes_total_o, w.tx);
        if (peak_rate_o !== w.peak) report_mismatch("peak", 64'(peak_rate_o), 64'(w.peak));
        if (avg_short_o !== w.avg_s) report_mismatch("avg_short", 64'(avg_short_o), 64'(w.avg_s));
        if (avg_mid_o !== w.avg_m) report_mismatch("avg_mid", 64'(avg_mid_o), 64'(w.avg_m));
        if (avg_long_o !== w.avg_l) report_mismatch("avg_long", 64'(avg_long_o), 64'(w.avg_l));
        if (last_seen_time_o !== w.last)
          report_mismatch("last_time", 64'(last_seen_time_o), 64'(w.last));
      end
    end
  end

  // main sequence
  initial begin
    int unsigned wait_cycles;
    win_short = 6'd2;
    win_mid = 6'd10;
    win_long = 6'd40;
    host_count = 0;
    clock_now = 32'd1000;
    for (int p = 0; p < PoolSize; p++) begin
      pool_v6[p] = (p % 3) != 0;
      pool_hi[p] = pool_v6[p] ? {$urandom, $urandom} : 64'd0;
      pool_lo[p] = pool_v6[p] ? {$urandom, $urandom} : 64'($urandom);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_windows();
    test_random();
    test_table_full();
    start <= 1'b0;
    wait_cycles = 0;
    while ((expected_results.size() != 0 || busy) && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d items (%0d reads), %0d results, %0d hosts in table",
             items_sent, reads_sent, results_seen, host_count);
    $display("window settings from zero to 63 seconds, full table and %0d errors", errors);
    if (errors == 0) begin
      $display("PASS per_host_traffic_meter_unit");
    end else begin
      $display("FAIL per_host_traffic_meter_unit");
    end
    $finish;
  end

  // run limit
  initial begin
    #100ms;
    $display("timeout");
    $display("FAIL per_host_traffic_meter_unit");
    $finish;
  end

endmodule
